// ===== design/tssm_pkg.sv =====
`timescale 1ns / 1ps

package tssm_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int OP_W   = 3;
  localparam int STAT_W = 3;
  localparam int DATA_W = 32;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [STAT_W-1:0]    status_t;
  typedef logic [WORD_BITS-1:0] store_word_t;
  typedef logic [DATA_W-1:0]    data_word_t;

  localparam op_t OP_PUSH_ONE = 3'd0;
  localparam op_t OP_PUSH_TWO = 3'd1;
  localparam op_t OP_POP_ONE  = 3'd2;
  localparam op_t OP_POP_TWO  = 3'd3;
  localparam op_t OP_LIST     = 3'd4;

  localparam status_t ST_PUSHED  = 3'd0;
  localparam status_t ST_POPPED  = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_LISTED  = 3'd4;
  localparam status_t ST_NOTHING = 3'd5;

  // low bits of the pushed word go to the store, zero filled if the store is wider
  function automatic store_word_t to_store(input data_word_t v);
    store_word_t r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = (i < DATA_W) ? v[i % DATA_W] : 1'b0;
    end
    return r;
  endfunction

  // low bits of the stored word go out, zero filled if the store is narrower
  function automatic data_word_t to_data(input store_word_t v);
    data_word_t r;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = (i < WORD_BITS) ? v[i % WORD_BITS] : 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/tssm_ram.sv =====
`timescale 1ns / 1ps

module tssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/two_stacks_shared_memory_core.sv =====
`timescale 1ns / 1ps

// Two LIFO stacks in one shared RAM: stack one grows up from address 0,
// stack two grows down from the top address.
// Input channel in_*: one transaction per command. in_tuser carries the
// operation (push one, push two, pop one, pop two, list), in_tdata the word
// to push. Codes 5 to 7 are taken and dropped without a result.
// Result channel out_*: out_tuser holds status and stack id, out_tdata the
// popped or listed word (zero otherwise), out_tlast marks the final result
// of a command.
// A push or pop is taken in the command cycle and its result is loaded into
// the output register once that is free; a pop waits on the registered RAM
// read. A list streams the stored words through the single RAM read port,
// fetching the next word while one goes out (one result if both are empty).
// One command is in work at a time; in_tready is high only between commands.
// Results go through an output register, so a stalled receiver simply holds
// the current result and freezes the list walk until out_tready returns.
// Reset clears both stack counts and the control state; RAM contents stay
// undefined and are never read before being written.
module two_stacks_shared_memory_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] word
  output logic [3:0]  out_tuser,  // [2:0] status, [3] stack_id
  output logic        out_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES  = 2'd1;
  localparam logic [1:0] S_LOUT = 2'd2;

  localparam logic [tssm_pkg::CNT_W-1:0] DEPTH_C = tssm_pkg::CNT_W'(tssm_pkg::DEPTH);
  localparam logic [tssm_pkg::CNT_W-1:0] ONE_C   = tssm_pkg::CNT_W'(1);

  logic [1:0] state_r, state_nxt;
  logic [tssm_pkg::CNT_W-1:0] cnt_lo_r, cnt_lo_nxt;
  logic [tssm_pkg::CNT_W-1:0] cnt_hi_r, cnt_hi_nxt;
  logic [tssm_pkg::CNT_W-1:0] pos_r, pos_nxt;

  tssm_pkg::status_t pend_status_r, pend_status_nxt;
  logic pend_sid_r, pend_sid_nxt;
  logic pend_rd_r, pend_rd_nxt;

  logic out_valid_r, out_valid_nxt;
  tssm_pkg::status_t out_status_r, out_status_nxt;
  logic out_sid_r, out_sid_nxt;
  tssm_pkg::data_word_t out_word_r, out_word_nxt;
  logic out_last_r, out_last_nxt;

  logic in_acc;
  logic slot_free;
  logic [tssm_pkg::CNT_W-1:0] used;
  logic full;
  logic [tssm_pkg::CNT_W-1:0] rd_pos;
  logic [tssm_pkg::CNT_W-1:0] list_addr_w;
  logic [tssm_pkg::CNT_W-1:0] push_two_pos;
  logic [tssm_pkg::CNT_W-1:0] pop_one_pos;
  logic [tssm_pkg::CNT_W-1:0] pop_two_pos;
  logic list_sid;
  logic list_last;
  tssm_pkg::op_t op;

  logic ram_we, ram_re;
  logic [tssm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  tssm_pkg::store_word_t ram_wdata, ram_rdata;

  tssm_ram #(
    .WIDTH(tssm_pkg::WORD_BITS),
    .DEPTH(tssm_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign slot_free = !out_valid_r || out_tready;
  assign used      = cnt_lo_r + cnt_hi_r;
  assign full      = (used == DEPTH_C);

  assign push_two_pos = DEPTH_C - ONE_C - cnt_hi_r;
  assign pop_one_pos  = cnt_lo_r - ONE_C;
  assign pop_two_pos  = DEPTH_C - cnt_hi_r;

  // list position to read: first word at command time, then the one after pos_r
  assign rd_pos      = (state_r == S_IDLE) ? '0 : pos_r + ONE_C;
  assign list_addr_w = (rd_pos < cnt_lo_r) ? rd_pos
                                           : DEPTH_C - ONE_C - (rd_pos - cnt_lo_r);
  assign list_sid    = (pos_r >= cnt_lo_r);
  assign list_last   = (pos_r == used - ONE_C);

  always_comb begin
    state_nxt       = state_r;
    cnt_lo_nxt      = cnt_lo_r;
    cnt_hi_nxt      = cnt_hi_r;
    pos_nxt         = pos_r;
    pend_status_nxt = pend_status_r;
    pend_sid_nxt    = pend_sid_r;
    pend_rd_nxt     = pend_rd_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_sid_nxt     = out_sid_r;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = tssm_pkg::to_store(in_tdata);
    ram_re          = 1'b0;
    ram_raddr       = list_addr_w[tssm_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_rd_nxt = 1'b0;
          case (op) inside
            tssm_pkg::OP_PUSH_ONE, tssm_pkg::OP_PUSH_TWO: begin
              pend_sid_nxt = (op == tssm_pkg::OP_PUSH_TWO);
              state_nxt    = S_RES;
              if (full) begin
                pend_status_nxt = tssm_pkg::ST_OVERFLOW;
              end else begin
                pend_status_nxt = tssm_pkg::ST_PUSHED;
                ram_we          = 1'b1;
                if (op == tssm_pkg::OP_PUSH_ONE) begin
                  ram_waddr  = cnt_lo_r[tssm_pkg::ADDR_W-1:0];
                  cnt_lo_nxt = cnt_lo_r + ONE_C;
                end else begin
                  ram_waddr  = push_two_pos[tssm_pkg::ADDR_W-1:0];
                  cnt_hi_nxt = cnt_hi_r + ONE_C;
                end
              end
            end
            tssm_pkg::OP_POP_ONE: begin
              pend_sid_nxt = 1'b0;
              state_nxt    = S_RES;
              if (cnt_lo_r == '0) begin
                pend_status_nxt = tssm_pkg::ST_UNDERFLOW;
              end else begin
                pend_status_nxt = tssm_pkg::ST_POPPED;
                pend_rd_nxt     = 1'b1;
                ram_re          = 1'b1;
                ram_raddr       = pop_one_pos[tssm_pkg::ADDR_W-1:0];
                cnt_lo_nxt      = cnt_lo_r - ONE_C;
              end
            end
            tssm_pkg::OP_POP_TWO: begin
              pend_sid_nxt = 1'b1;
              state_nxt    = S_RES;
              if (cnt_hi_r == '0) begin
                pend_status_nxt = tssm_pkg::ST_UNDERFLOW;
              end else begin
                pend_status_nxt = tssm_pkg::ST_POPPED;
                pend_rd_nxt     = 1'b1;
                ram_re          = 1'b1;
                ram_raddr       = pop_two_pos[tssm_pkg::ADDR_W-1:0];
                cnt_hi_nxt      = cnt_hi_r - ONE_C;
              end
            end
            tssm_pkg::OP_LIST: begin
              if (used == '0) begin
                pend_status_nxt = tssm_pkg::ST_NOTHING;
                pend_sid_nxt    = 1'b0;
                state_nxt       = S_RES;
              end else begin
                ram_re    = 1'b1;
                pos_nxt   = '0;
                state_nxt = S_LOUT;
              end
            end
            default: begin
              // undefined operation: dropped without a result
            end
          endcase
        end
      end
      S_RES: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_sid_nxt    = pend_sid_r;
          out_word_nxt   = pend_rd_r ? tssm_pkg::to_data(ram_rdata) : '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LOUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = tssm_pkg::ST_LISTED;
          out_sid_nxt    = list_sid;
          out_word_nxt   = tssm_pkg::to_data(ram_rdata);
          out_last_nxt   = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next word while this one goes out
            ram_re  = 1'b1;
            pos_nxt = rd_pos;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_lo_r    <= '0;
      cnt_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_lo_r    <= cnt_lo_nxt;
      cnt_hi_r    <= cnt_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    pend_status_r <= pend_status_nxt;
    pend_sid_r    <= pend_sid_nxt;
    pend_rd_r     <= pend_rd_nxt;
    out_status_r  <= out_status_nxt;
    out_sid_r     <= out_sid_nxt;
    out_word_r    <= out_word_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = {out_sid_r, out_status_r};
  assign out_tlast  = out_last_r;

  // the two stacks never claim more words than the RAM holds
  a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_lo_r + cnt_hi_r) <= DEPTH_C)
    else $error("stack counts exceed ram depth");

  // a push into a store with room grows the total by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full && (op == tssm_pkg::OP_PUSH_ONE || op == tssm_pkg::OP_PUSH_TWO))
    |=> (used == $past(used) + ONE_C))
    else $error("push did not grow the stacks by one");

  // a pop from a non-empty stack waits for the ram read before reporting
  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == tssm_pkg::OP_POP_ONE && cnt_lo_r != '0)
    |=> (state_r == S_RES && pend_rd_r && cnt_lo_r == $past(cnt_lo_r) - ONE_C))
    else $error("pop one did not set up a read");

  // the list walk stays inside the stored words and leaves counts alone
  a_list_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOUT) |-> (pos_r < used && $stable(cnt_lo_r) && $stable(cnt_hi_r)))
    else $error("list walk out of range");

endmodule
